// File: rtl/page_framebuffer_refresh_serializer_assert.svh
// Assertion macros for the page framebuffer refresh serializer.
`ifndef PAGE_FRAMEBUFFER_REFRESH_SERIALIZER_ASSERT_SVH
`define PAGE_FRAMEBUFFER_REFRESH_SERIALIZER_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off during reset.
`define PFRS_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off during reset.
`define PFRS_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define PFRS_ASSERT_IMPLIES(name, ante, cons)
`define PFRS_ASSERT_NEXT(name, ante, cons)

`endif

`endif

// File: rtl/pfrs_pkg.sv
// Shared types and constants of the page framebuffer refresh serializer.
package pfrs_pkg;

	localparam int COLUMNS_DEFAULT = 128;
	localparam int PAGES_DEFAULT = 8;

	localparam int CMD_W = 2;
	localparam int X_W = 7;
	localparam int Y_W = 6;
	localparam int BYTE_W = 8;

	localparam int HEAD_SLOTS = 3;
	localparam int SLOT_PAGE = 0;
	localparam int SLOT_COL_LOW = 1;
	localparam int SLOT_COL_HIGH = 2;

	localparam logic [7:0] PAGE_CMD_BASE = 8'hB0;
	localparam logic [7:0] COL_LOW_CMD = 8'h00;
	localparam logic [7:0] COL_HIGH_CMD = 8'h10;

	typedef enum logic [1:0] {
		CMD_SET = 2'd0,
		CMD_CLEAR = 2'd1,
		CMD_CLEAR_FRAME = 2'd2,
		CMD_REFRESH = 2'd3
	} cmd_t;

	// Controller to datapath
	typedef struct packed {
		logic take;      // input transaction accepted this cycle
		logic rmw_wr;    // write back the modified byte
		logic out_load;  // load the result register
		logic sweep_wr;  // write zero at the sweep address
	} ctrl_t;

	// Datapath to controller
	typedef struct packed {
		logic out_free;
		logic sweep_done;
	} status_t;

endpackage

// File: rtl/pfrs_chan_if.sv
// Valid/ready channel interfaces for command items and refresh bytes.
interface pfrs_item_if;
	logic valid;
	logic ready;
	logic [pfrs_pkg::CMD_W-1:0] cmd;
	logic [pfrs_pkg::X_W-1:0] pixel_x;
	logic [pfrs_pkg::Y_W-1:0] pixel_y;

	modport source(output valid, cmd, pixel_x, pixel_y, input ready);
	modport sink(input valid, cmd, pixel_x, pixel_y, output ready);
endinterface

interface pfrs_result_if;
	logic valid;
	logic ready;
	logic [pfrs_pkg::BYTE_W-1:0] out_byte;
	logic is_data;
	logic frame_last;

	modport source(output valid, out_byte, is_data, frame_last, input ready);
	modport sink(input valid, out_byte, is_data, frame_last, output ready);
endinterface

// File: rtl/pfrs_ram.sv
// Generic simple dual-port RAM with registered read.
module pfrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: rtl/pfrs_ctrl.sv
// Controller state machine of the page framebuffer refresh serializer.
module pfrs_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [pfrs_pkg::CMD_W-1:0] in_cmd,
	output logic                       in_ready,
	input  pfrs_pkg::status_t          status,
	output pfrs_pkg::ctrl_t            ctl
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_MODIFY = 4'b0010,
		ST_EMIT   = 4'b0100,
		ST_SWEEP  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		ctl = '0;
		ctl.take = in_valid && in_ready;
		unique case (state_q)
			ST_IDLE: begin
				if (ctl.take) begin
					unique case (pfrs_pkg::cmd_t'(in_cmd))
						pfrs_pkg::CMD_SET,
						pfrs_pkg::CMD_CLEAR:       state_d = ST_MODIFY;
						pfrs_pkg::CMD_CLEAR_FRAME: state_d = ST_SWEEP;
						pfrs_pkg::CMD_REFRESH:     state_d = ST_EMIT;
					endcase
				end
			end
			ST_MODIFY: begin
				ctl.rmw_wr = 1'b1;
				state_d = ST_IDLE;
			end
			ST_EMIT: begin
				// hold until the result register can take the byte
				if (status.out_free) begin
					ctl.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_SWEEP: begin
				ctl.sweep_wr = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_SWEEP;
		endcase
	end

	// reset enters the sweep so the store starts out all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/pfrs_datapath.sv
// Datapath: frame store, pixel read-modify-write, refresh position and result register.
module pfrs_datapath #(
	parameter int COLUMNS = pfrs_pkg::COLUMNS_DEFAULT,
	parameter int PAGES = pfrs_pkg::PAGES_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pfrs_pkg::ctrl_t             ctl,
	output pfrs_pkg::status_t           status,
	input  logic [pfrs_pkg::CMD_W-1:0]  in_cmd,
	input  logic [pfrs_pkg::X_W-1:0]    in_x,
	input  logic [pfrs_pkg::Y_W-1:0]    in_y,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [pfrs_pkg::BYTE_W-1:0] out_byte,
	output logic                        out_is_data,
	output logic                        out_last
);

	localparam int DEPTH = PAGES * COLUMNS;
	localparam int AW = $clog2(DEPTH);
	localparam int SLOTS = COLUMNS + pfrs_pkg::HEAD_SLOTS;
	localparam int SW = $clog2(SLOTS);
	localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [SW-1:0] slot_q;
	logic [PW-1:0] page_q;
	logic [AW-1:0] clr_addr_q;
	logic          out_valid_q;

	logic [AW-1:0] op_addr_q;
	logic [7:0]    mask_q;
	logic          set_q;
	logic          range_q;
	logic [7:0]    cmd_byte_q;
	logic          is_data_q;
	logic          last_q;
	logic [7:0]    out_byte_q;
	logic          out_is_data_q;
	logic          out_last_q;

	logic [2:0]    pix_page;
	logic          pix_in_range;
	logic [AW-1:0] pix_addr;
	logic [AW-1:0] ref_addr;
	logic          is_refresh;
	logic          slot_end;
	logic          page_end;
	logic [7:0]    head_byte;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;

	assign pix_page = in_y[pfrs_pkg::Y_W-1:3];
	assign pix_in_range = (9'(in_x) < 9'(COLUMNS)) && (5'(pix_page) < 5'(PAGES));
	assign pix_addr = AW'(32'(pix_page) * 32'(COLUMNS) + 32'(in_x));
	assign ref_addr = AW'(32'(page_q) * 32'(COLUMNS) + 32'(slot_q)
		- 32'(pfrs_pkg::HEAD_SLOTS));
	assign is_refresh = (in_cmd == pfrs_pkg::CMD_REFRESH);
	assign slot_end = (slot_q == SW'(SLOTS - 1));
	assign page_end = (page_q == PW'(PAGES - 1));

	always_comb begin
		priority if (slot_q == SW'(pfrs_pkg::SLOT_PAGE)) begin
			head_byte = pfrs_pkg::PAGE_CMD_BASE + 8'(page_q);
		end else if (slot_q == SW'(pfrs_pkg::SLOT_COL_LOW)) begin
			head_byte = pfrs_pkg::COL_LOW_CMD;
		end else begin
			head_byte = pfrs_pkg::COL_HIGH_CMD;
		end
	end

	assign rd_addr = is_refresh ? ref_addr : pix_addr;
	assign wr_en = ctl.sweep_wr || (ctl.rmw_wr && range_q);
	assign wr_addr = ctl.sweep_wr ? clr_addr_q : op_addr_q;
	assign wr_data = ctl.sweep_wr ? 8'h00 : (set_q ? (rd_data | mask_q) : (rd_data & ~mask_q));

	pfrs_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(ctl.take),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			page_q <= '0;
			clr_addr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// advance the refresh position once per refresh transaction
			if (ctl.take && is_refresh) begin
				if (slot_end) begin
					slot_q <= '0;
					page_q <= page_end ? '0 : page_q + PW'(1);
				end else begin
					slot_q <= slot_q + SW'(1);
				end
			end
			if (ctl.sweep_wr) begin
				clr_addr_q <= status.sweep_done ? '0 : clr_addr_q + AW'(1);
			end
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take) begin
			op_addr_q <= pix_addr;
			mask_q <= 8'(1) << in_y[2:0];
			set_q <= (in_cmd == pfrs_pkg::CMD_SET);
			range_q <= pix_in_range;
			cmd_byte_q <= head_byte;
			is_data_q <= (slot_q >= SW'(pfrs_pkg::HEAD_SLOTS));
			last_q <= slot_end && page_end;
		end
		if (ctl.out_load) begin
			out_byte_q <= is_data_q ? rd_data : cmd_byte_q;
			out_is_data_q <= is_data_q;
			out_last_q <= last_q;
		end
	end

	assign status.out_free = !out_valid_q || out_ready;
	assign status.sweep_done = (clr_addr_q == AW'(DEPTH - 1));

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_is_data = out_is_data_q;
	assign out_last = out_last_q;

endmodule

// File: rtl/page_framebuffer_refresh_serializer.sv
// Top level of the page framebuffer refresh serializer.
// Takes one command transaction at a time on item and returns refresh bytes on result.
// Set and clear pixel do a registered store read, then a write-back; a refresh
// byte is a registered store read, then a load once the result register drains; the
// result register lets the next transaction enter while a byte waits. Clear frame
// sweeps the store to zero one byte a cycle, then returns to idle. After reset the
// same sweep runs with item.ready low.
// The refresh stream per page is 0xB0+page, 0x00, 0x10, then COLUMNS data bytes;
// frame_last marks the final data byte of the final page.
`include "page_framebuffer_refresh_serializer_assert.svh"

module page_framebuffer_refresh_serializer #(
	parameter int COLUMNS = pfrs_pkg::COLUMNS_DEFAULT,
	parameter int PAGES = pfrs_pkg::PAGES_DEFAULT
) (
	input logic           clk,
	input logic           arst_n,
	pfrs_item_if.sink     item,
	pfrs_result_if.source result
);

	pfrs_pkg::ctrl_t   ctl;
	pfrs_pkg::status_t status;
	logic              pixel_take;

	pfrs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(item.valid),
		.in_cmd(item.cmd),
		.in_ready(item.ready),
		.status(status),
		.ctl(ctl)
	);

	pfrs_datapath #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ctl),
		.status(status),
		.in_cmd(item.cmd),
		.in_x(item.pixel_x),
		.in_y(item.pixel_y),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.out_byte(result.out_byte),
		.out_is_data(result.is_data),
		.out_last(result.frame_last)
	);

	assign pixel_take = item.valid && item.ready &&
		(item.cmd == pfrs_pkg::CMD_SET || item.cmd == pfrs_pkg::CMD_CLEAR);

	`PFRS_ASSERT_IMPLIES(a_last_is_data, result.valid && result.frame_last, result.is_data)
	`PFRS_ASSERT_NEXT(a_pixel_writes_back, pixel_take, ctl.rmw_wr)
	`PFRS_ASSERT_NEXT(a_load_shows_result, ctl.out_load, result.valid)

endmodule
